// ===== design/plf_pkg.sv =====
// Shared constants, codes, types and helpers of the Playfair digraph encryptor.
// No dependencies; every other file refers to it by scoped names.
package plf_pkg;

	localparam int LETTER_W = 5;
	localparam int COORD_W  = 3;
	localparam int SIDE     = 5;
	localparam int CELLS    = SIDE * SIDE;

	localparam logic [LETTER_W-1:0] LETTER_E    = 5'd4;
	localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_X    = 5'd23;
	localparam logic [LETTER_W-1:0] LAST_CODE   = 5'd25;
	localparam logic [LETTER_W-1:0] NUM_LETTERS = 5'd26;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_KEY   = 2'd1;
	localparam logic [1:0] OP_MSG   = 2'd2;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [COORD_W-1:0]  coord_t;

	typedef struct packed {
		logic    clear;
		logic    place;
		letter_t wr_letter;
		letter_t qa;
		letter_t qb;
		coord_t  tra;
		coord_t  tca;
		coord_t  trb;
		coord_t  tcb;
	} sq_req_t;

	typedef struct packed {
		logic    full;
		coord_t  ra;
		coord_t  ca;
		coord_t  rb;
		coord_t  cb;
		letter_t la;
		letter_t lb;
	} sq_rsp_t;

	function automatic letter_t filler_for(input letter_t code);
		return (code == LETTER_X) ? LETTER_E : LETTER_X;
	endfunction

	function automatic coord_t wrap_inc(input coord_t v);
		return (v == coord_t'(SIDE - 1)) ? coord_t'(0) : coord_t'(v + coord_t'(1));
	endfunction

endpackage

// ===== design/plf_in_if.sv =====
// Input channel of the encryptor: op, letter and last with a valid/ready transfer.
// Depends on plf_pkg for the letter type.
interface plf_in_if;
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	plf_pkg::letter_t letter;
	logic             last;

	modport source (output valid, output op, output letter, output last, input ready);
	modport sink   (input valid, input op, input letter, input last, output ready);
endinterface

// ===== design/plf_out_if.sv =====
// Output channel of the encryptor: cipher letter and end marks with a valid/ready transfer.
// Depends on plf_pkg for the letter type.
interface plf_out_if;
	logic             valid;
	logic             ready;
	plf_pkg::letter_t cipher_letter;
	logic             run_end;
	logic             message_end;

	modport source (output valid, output cipher_letter, output run_end, output message_end,
		input ready);
	modport sink   (input valid, input cipher_letter, input run_end, input message_end,
		output ready);
endinterface

// ===== design/playfair_digraph_encryptor.sv =====
// Playfair digraph encryptor. Op 0 clears the square, op 1 adds a key letter, op 2
// encrypts a message letter. The first message letter after a clear first walks the
// alphabet through the cell row, one letter a cycle, to complete the square. A message
// letter then passes a decide step; each digraph it releases (up to two with last set)
// goes through lookup in the cell row (positions, then letters) and two output transfers,
// which stall while the sink holds ready low. One item is in work at a time: a new item
// is taken once all results of the previous one are transferred.
module playfair_digraph_encryptor (
	input  logic      clk,
	input  logic      arst_n,
	plf_in_if.sink    in_ch,
	plf_out_if.source out_ch
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FILL   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_LOOK   = 7'b0001000,
		S_READ   = 7'b0010000,
		S_OUT0   = 7'b0100000,
		S_OUT1   = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [25:0]      used_q;
	logic             complete_q;
	logic             pend_q;
	plf_pkg::letter_t pcode_q;
	plf_pkg::letter_t walk_q;
	plf_pkg::letter_t letter_q;
	logic             last_q;
	plf_pkg::letter_t pa_q;
	plf_pkg::letter_t pb_q;
	logic             more_q;
	plf_pkg::letter_t flcode_q;
	plf_pkg::coord_t  ra_s1, ca_s1, rb_s1, cb_s1;
	plf_pkg::letter_t o0_s2, o1_s2;

	plf_pkg::sq_req_t sq_req;
	plf_pkg::sq_rsp_t sq_rsp;
	logic [31:0]      used_ext;
	logic             in_xfer;
	logic             key_place;
	logic             walk_place;
	plf_pkg::letter_t m_code;
	logic             dec_pair;
	plf_pkg::letter_t dec_a, dec_b;
	logic             dec_pend;
	plf_pkg::letter_t dec_pcode;
	logic             dec_flush;

	assign used_ext = {6'b0, used_q};
	assign in_xfer  = in_ch.valid && in_ch.ready;

	function automatic logic blocked(input plf_pkg::letter_t c, input logic [31:0] u);
		return (c == plf_pkg::LETTER_I && u[plf_pkg::LETTER_J]) ||
			(c == plf_pkg::LETTER_J && u[plf_pkg::LETTER_I]);
	endfunction

	assign key_place = in_xfer && (in_ch.op == plf_pkg::OP_KEY) &&
		(in_ch.letter < plf_pkg::NUM_LETTERS) && !complete_q &&
		!used_ext[in_ch.letter] && !blocked(in_ch.letter, used_ext) && !sq_rsp.full;
	assign walk_place = (state_q == S_FILL) && !used_ext[walk_q] &&
		!blocked(walk_q, used_ext) && !sq_rsp.full;

	// map the absent one of i and j onto the present one
	always_comb begin
		m_code = letter_q;
		if (letter_q == plf_pkg::LETTER_I && !used_q[plf_pkg::LETTER_I]) begin
			m_code = plf_pkg::LETTER_J;
		end else if (letter_q == plf_pkg::LETTER_J && !used_q[plf_pkg::LETTER_J]) begin
			m_code = plf_pkg::LETTER_I;
		end
	end

	always_comb begin
		dec_pair  = 1'b0;
		dec_a     = pcode_q;
		dec_b     = m_code;
		dec_pend  = pend_q;
		dec_pcode = pcode_q;
		if (letter_q < plf_pkg::NUM_LETTERS) begin
			if (!pend_q) begin
				dec_pend  = 1'b1;
				dec_pcode = m_code;
			end else if (pcode_q == m_code) begin
				dec_pair = 1'b1;
				dec_a    = m_code;
				dec_b    = plf_pkg::filler_for(m_code);
			end else begin
				dec_pair = 1'b1;
				dec_pend = 1'b0;
			end
		end
		dec_flush = last_q && dec_pend;
		if (dec_flush) begin
			dec_pend = 1'b0;
		end
	end

	always_comb begin
		sq_req           = '0;
		sq_req.clear     = in_xfer && (in_ch.op == plf_pkg::OP_CLEAR);
		sq_req.place     = key_place || walk_place;
		sq_req.wr_letter = key_place ? in_ch.letter : walk_q;
		sq_req.qa        = pa_q;
		sq_req.qb        = pb_q;
		if (ra_s1 == rb_s1) begin
			sq_req.tra = ra_s1;
			sq_req.tca = plf_pkg::wrap_inc(ca_s1);
			sq_req.trb = rb_s1;
			sq_req.tcb = plf_pkg::wrap_inc(cb_s1);
		end else if (ca_s1 == cb_s1) begin
			sq_req.tra = plf_pkg::wrap_inc(ra_s1);
			sq_req.tca = ca_s1;
			sq_req.trb = plf_pkg::wrap_inc(rb_s1);
			sq_req.tcb = cb_s1;
		end else begin
			sq_req.tra = ra_s1;
			sq_req.tca = cb_s1;
			sq_req.trb = rb_s1;
			sq_req.tcb = ca_s1;
		end
	end

	plf_square u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			complete_q <= 1'b0;
			pend_q     <= 1'b0;
			pcode_q    <= '0;
			walk_q     <= '0;
			more_q     <= 1'b0;
		end else begin
			if (sq_req.place) begin
				used_q[sq_req.wr_letter] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (in_ch.op)
							plf_pkg::OP_CLEAR: begin
								used_q     <= '0;
								complete_q <= 1'b0;
								pend_q     <= 1'b0;
								pcode_q    <= '0;
							end
							plf_pkg::OP_MSG: begin
								walk_q  <= '0;
								state_q <= complete_q ? S_DECIDE : S_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				S_FILL: begin
					walk_q <= plf_pkg::letter_t'(walk_q + 5'd1);
					if (walk_q == plf_pkg::LAST_CODE) begin
						complete_q <= 1'b1;
						state_q    <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					pend_q  <= dec_pend;
					pcode_q <= dec_pcode;
					more_q  <= dec_pair && dec_flush;
					if (dec_pair || dec_flush) begin
						state_q <= S_LOOK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LOOK: state_q <= S_READ;
				S_READ: state_q <= S_OUT0;
				S_OUT0: begin
					if (out_ch.ready) begin
						state_q <= S_OUT1;
					end
				end
				S_OUT1: begin
					if (out_ch.ready) begin
						more_q  <= 1'b0;
						state_q <= more_q ? S_LOOK : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			letter_q <= in_ch.letter;
			last_q   <= in_ch.last;
		end
		if (state_q == S_DECIDE) begin
			flcode_q <= dec_pcode;
			if (dec_pair) begin
				pa_q <= dec_a;
				pb_q <= dec_b;
			end else begin
				pa_q <= dec_pcode;
				pb_q <= plf_pkg::filler_for(dec_pcode);
			end
		end
		if (state_q == S_OUT1 && out_ch.ready && more_q) begin
			pa_q <= flcode_q;
			pb_q <= plf_pkg::filler_for(flcode_q);
		end
		if (state_q == S_LOOK) begin
			ra_s1 <= sq_rsp.ra;
			ca_s1 <= sq_rsp.ca;
			rb_s1 <= sq_rsp.rb;
			cb_s1 <= sq_rsp.cb;
		end
		if (state_q == S_READ) begin
			o0_s2 <= sq_rsp.la;
			o1_s2 <= sq_rsp.lb;
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = (state_q == S_OUT0) || (state_q == S_OUT1);
	assign out_ch.cipher_letter = (state_q == S_OUT1) ? o1_s2 : o0_s2;
	assign out_ch.run_end       = (state_q == S_OUT1) && !more_q;
	assign out_ch.message_end   = (state_q == S_OUT1) && !more_q && last_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost its one-hot code");

	a_msg_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.message_end |-> out_ch.run_end)
		else $error("message end without run end");

	a_fill_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL && walk_q == plf_pkg::LAST_CODE |=> sq_rsp.full)
		else $error("square not full after completion walk");

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input taken while a result is offered");

endmodule

// ===== design/plf_cell.sv =====
// One cell of the key square: holds a letter and its fill flag, matches lookups.
// Fills on a place request when its left neighbour is filled and it is not. Depends on plf_pkg.
module plf_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             place,
	input  plf_pkg::letter_t wr_letter,
	input  logic             prev_valid,
	input  plf_pkg::letter_t qa,
	input  plf_pkg::letter_t qb,
	output logic             valid,
	output logic             hit_a,
	output logic             hit_b,
	output plf_pkg::letter_t letter
);

	logic             valid_q;
	plf_pkg::letter_t letter_q;
	logic             take;

	assign take = place && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			letter_q <= wr_letter;
		end
	end

	assign valid  = valid_q;
	assign letter = letter_q;
	assign hit_a  = valid_q && (letter_q == qa);
	assign hit_b  = valid_q && (letter_q == qb);

endmodule

// ===== design/plf_square.sv =====
// The 5x5 key square as a row of plf_cell instances filled in order.
// Finds positions of two letters and reads letters at two positions. Depends on plf_pkg.
module plf_square (
	input  logic             clk,
	input  logic             arst_n,
	input  plf_pkg::sq_req_t req,
	output plf_pkg::sq_rsp_t rsp
);

	logic [plf_pkg::CELLS-1:0] valid;
	logic [plf_pkg::CELLS-1:0] hit_a;
	logic [plf_pkg::CELLS-1:0] hit_b;
	plf_pkg::letter_t          cell_letter [plf_pkg::CELLS];

	for (genvar i = 0; i < plf_pkg::CELLS; i++) begin : g_cell
		logic prev_valid;
		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = valid[i-1];
		end
		plf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear      (req.clear),
			.place      (req.place),
			.wr_letter  (req.wr_letter),
			.prev_valid (prev_valid),
			.qa         (req.qa),
			.qb         (req.qb),
			.valid      (valid[i]),
			.hit_a      (hit_a[i]),
			.hit_b      (hit_b[i]),
			.letter     (cell_letter[i])
		);
	end

	always_comb begin
		rsp      = '0;
		rsp.full = valid[plf_pkg::CELLS-1];
		for (int i = 0; i < plf_pkg::CELLS; i++) begin
			if (hit_a[i]) begin
				rsp.ra = rsp.ra | plf_pkg::coord_t'(i / plf_pkg::SIDE);
				rsp.ca = rsp.ca | plf_pkg::coord_t'(i % plf_pkg::SIDE);
			end
			if (hit_b[i]) begin
				rsp.rb = rsp.rb | plf_pkg::coord_t'(i / plf_pkg::SIDE);
				rsp.cb = rsp.cb | plf_pkg::coord_t'(i % plf_pkg::SIDE);
			end
			if (req.tra == plf_pkg::coord_t'(i / plf_pkg::SIDE) &&
				req.tca == plf_pkg::coord_t'(i % plf_pkg::SIDE)) begin
				rsp.la = rsp.la | cell_letter[i];
			end
			if (req.trb == plf_pkg::coord_t'(i / plf_pkg::SIDE) &&
				req.tcb == plf_pkg::coord_t'(i % plf_pkg::SIDE)) begin
				rsp.lb = rsp.lb | cell_letter[i];
			end
		end
	end

endmodule
